### sv/u8n1_pkg.sv
package u8n1_pkg;

    localparam int unsigned CFG_W = 16;
    localparam int unsigned CFG_ADDR_W = 1;
    localparam int unsigned BYTE_W = 8;
    localparam int unsigned BIT_IDX_W = 4;

    localparam logic [CFG_ADDR_W-1:0] REG_BIT_PERIOD = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] REG_HALF_PERIOD = 1'b1;

    localparam logic [CFG_W-1:0] BIT_PERIOD_RESET = 16'd52;
    localparam logic [CFG_W-1:0] HALF_PERIOD_RESET = 16'd26;

    // frame layout: start bit, eight data bits, stop bit
    localparam logic [BIT_IDX_W-1:0] IDX_START = 4'd0;
    localparam logic [BIT_IDX_W-1:0] IDX_LAST_DATA = 4'd8;
    localparam logic [BIT_IDX_W-1:0] IDX_STOP = 4'd9;

    typedef struct packed {
        logic [CFG_W-1:0] bit_period;
        logic [CFG_W-1:0] half_period;
    } timing_t;

    // one tick counts as the end of a bit when timer + 1 reaches the limit
    function automatic logic period_done(input logic [CFG_W-1:0] timer,
                                         input logic [CFG_W-1:0] limit);
        logic [CFG_W:0] sum;
        sum = {1'b0, timer} + {{CFG_W{1'b0}}, 1'b1};
        return sum >= {1'b0, limit};
    endfunction

endpackage

### sv/u8n1_tx.sv
module u8n1_tx (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          advance,
    input  u8n1_pkg::timing_t             timing,
    input  logic                          tx_start,
    input  logic [u8n1_pkg::BYTE_W-1:0]   tx_data,
    output logic                          tx_line,
    output logic                          tx_busy
);

    logic [u8n1_pkg::BYTE_W-1:0]    shift_reg, shift_next;
    logic [u8n1_pkg::BIT_IDX_W-1:0] idx_reg, idx_next;
    logic [u8n1_pkg::CFG_W-1:0]     timer_reg, timer_next;
    logic                           active_reg, active_next;

    logic [u8n1_pkg::BYTE_W-1:0]    cur_shift;
    logic [u8n1_pkg::BIT_IDX_W-1:0] cur_idx;
    logic [u8n1_pkg::BIT_IDX_W-1:0] data_pos;
    logic [u8n1_pkg::CFG_W-1:0]     cur_timer;
    logic                           load;
    logic [u8n1_pkg::CFG_W-1:0]     eff_period;

    assign load = !active_reg && tx_start;
    assign cur_shift = load ? tx_data : shift_reg;
    assign cur_idx = load ? u8n1_pkg::IDX_START : idx_reg;
    assign cur_timer = load ? '0 : timer_reg;
    assign data_pos = cur_idx - 4'd1;
    assign eff_period = (timing.bit_period == '0) ? 16'd1 : timing.bit_period;

    always_comb
    begin
        tx_busy = active_reg || tx_start;
        tx_line = 1'b1;
        shift_next = cur_shift;
        idx_next = cur_idx;
        timer_next = cur_timer;
        active_next = tx_busy;
        if (tx_busy)
        begin
            if (cur_idx == u8n1_pkg::IDX_START)
                tx_line = 1'b0;
            else if (cur_idx <= u8n1_pkg::IDX_LAST_DATA)
                tx_line = cur_shift[data_pos[2:0]];
            if (u8n1_pkg::period_done(cur_timer, eff_period))
            begin
                timer_next = '0;
                if (cur_idx == u8n1_pkg::IDX_STOP)
                begin
                    idx_next = u8n1_pkg::IDX_START;
                    active_next = 1'b0;
                end
                else
                    idx_next = cur_idx + 4'd1;
            end
            else
                timer_next = cur_timer + 16'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shift_reg <= '0;
            idx_reg <= '0;
            timer_reg <= '0;
            active_reg <= 1'b0;
        end
        else if (advance)
        begin
            shift_reg <= shift_next;
            idx_reg <= idx_next;
            timer_reg <= timer_next;
            active_reg <= active_next;
        end
    end

endmodule

### sv/u8n1_rx.sv
module u8n1_rx (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          advance,
    input  u8n1_pkg::timing_t             timing,
    input  logic                          rx_line,
    output logic                          rx_valid,
    output logic [u8n1_pkg::BYTE_W-1:0]   rx_data
);

    typedef enum logic [1:0] {
        RX_IDLE = 2'd0,
        RX_HALF = 2'd1,
        RX_BITS = 2'd2
    } rx_phase_t;

    rx_phase_t                      phase_reg, phase_next;
    logic [u8n1_pkg::CFG_W-1:0]     timer_reg, timer_next;
    logic [u8n1_pkg::BIT_IDX_W-1:0] idx_reg, idx_next;
    logic [u8n1_pkg::BYTE_W-1:0]    shift_reg, shift_next;
    logic [u8n1_pkg::CFG_W-1:0]     eff_period;

    assign eff_period = (timing.bit_period == '0) ? 16'd1 : timing.bit_period;

    always_comb
    begin
        phase_next = phase_reg;
        timer_next = timer_reg;
        idx_next = idx_reg;
        shift_next = shift_reg;
        rx_valid = 1'b0;
        rx_data = '0;
        unique case (phase_reg)
            RX_HALF:
            begin
                if (u8n1_pkg::period_done(timer_reg, timing.half_period))
                begin
                    phase_next = RX_BITS;
                    timer_next = '0;
                end
                else
                    timer_next = timer_reg + 16'd1;
            end
            RX_BITS:
            begin
                if (u8n1_pkg::period_done(timer_reg, eff_period))
                begin
                    timer_next = '0;
                    if (idx_reg < u8n1_pkg::IDX_LAST_DATA)
                    begin
                        shift_next = {rx_line, shift_reg[u8n1_pkg::BYTE_W-1:1]};
                        idx_next = idx_reg + 4'd1;
                    end
                    else
                    begin
                        rx_valid = 1'b1;
                        rx_data = shift_reg;
                        phase_next = RX_IDLE;
                        idx_next = '0;
                    end
                end
                else
                    timer_next = timer_reg + 16'd1;
            end
            default:
            begin
                phase_next = RX_IDLE;
                if (!rx_line)
                begin
                    shift_next = '0;
                    idx_next = '0;
                    timer_next = '0;
                    phase_next = (timing.half_period == '0) ? RX_BITS : RX_HALF;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= RX_IDLE;
            timer_reg <= '0;
            idx_reg <= '0;
            shift_reg <= '0;
        end
        else if (advance)
        begin
            phase_reg <= phase_next;
            timer_reg <= timer_next;
            idx_reg <= idx_next;
            shift_reg <= shift_next;
        end
    end

endmodule

### sv/uart_8n1_tx_rx.sv
// tick-timed 8n1 serial transmitter and receiver
// input stream: one transfer per serial tick, carrying the sampled receive
//   line and an optional send request with its byte
// output stream: one transfer per input transfer, in order, carrying the
//   transmit line level, the busy flag and any byte completed on that tick
// configuration: cfg_we with cfg_addr 0 writes bit_period, 1 writes
//   half_period; write only while no transfer is in flight
// latency: a result is presented the cycle after its tick is taken
// throughput: one tick per cycle; all tx and rx state updates for a tick
//   fit in the single stage between the state registers and the output
//   register
// reset: both engines idle, tx line high, bit_period 52, half_period 26
// stall: while m_axis_tready is low the output register holds its result;
//   s_axis_tready is high while that register is empty or is drained in
//   the same cycle, and the tx and rx engines advance only on taken ticks
module uart_8n1_tx_rx (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [u8n1_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [u8n1_pkg::CFG_W-1:0]    cfg_wdata,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // rx_line, tx_data, zero fill
    input  logic [15:0]                   s_axis_tdata,
    // tx_start
    input  logic                          s_axis_tuser,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // tx_line, tx_busy, rx_data, zero fill
    output logic [15:0]                   m_axis_tdata,
    // rx_valid
    output logic                          m_axis_tuser
);

    u8n1_pkg::timing_t              timing_reg;
    logic                           advance;
    logic                           tx_line;
    logic                           tx_busy;
    logic                           rx_valid;
    logic [u8n1_pkg::BYTE_W-1:0]    rx_data;
    logic                           out_valid_reg;
    logic [15:0]                    out_data_reg;
    logic                           out_user_reg;

    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign advance = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timing_reg.bit_period <= u8n1_pkg::BIT_PERIOD_RESET;
            timing_reg.half_period <= u8n1_pkg::HALF_PERIOD_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                u8n1_pkg::REG_BIT_PERIOD:  timing_reg.bit_period <= cfg_wdata;
                u8n1_pkg::REG_HALF_PERIOD: timing_reg.half_period <= cfg_wdata;
                default: ;
            endcase
        end
    end

    u8n1_tx u_tx (
        .clk      (clk),
        .rst_n    (rst_n),
        .advance  (advance),
        .timing   (timing_reg),
        .tx_start (s_axis_tuser),
        .tx_data  (s_axis_tdata[8:1]),
        .tx_line  (tx_line),
        .tx_busy  (tx_busy)
    );

    u8n1_rx u_rx (
        .clk      (clk),
        .rst_n    (rst_n),
        .advance  (advance),
        .timing   (timing_reg),
        .rx_line  (s_axis_tdata[0]),
        .rx_valid (rx_valid),
        .rx_data  (rx_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= 1'b1;
        else if (m_axis_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_data_reg <= {6'd0, rx_data, tx_busy, tx_line};
            out_user_reg <= rx_valid;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata = out_data_reg;
    assign m_axis_tuser = out_user_reg;

endmodule

### sv/u8n1_checker.sv
module u8n1_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata,
    input logic        m_axis_tuser
);

    // an empty output register always leaves the input ready for a tick
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with empty output register");

    // every taken tick yields a result on the next cycle
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> m_axis_tvalid)
        else $error("result missing after taken tick");

    // a drained result with no new tick leaves the output empty
    a_no_repeat: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tready && !(s_axis_tvalid && s_axis_tready))
        |=> !m_axis_tvalid)
        else $error("result repeated");

    // received byte field is zero unless a byte completes
    a_rx_data_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata[9:2] == 8'd0))
        else $error("rx data set without rx valid");

    // an idle transmitter holds the line high
    a_idle_line_high: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tdata[1]) |-> m_axis_tdata[0])
        else $error("tx line low while idle");

endmodule

bind uart_8n1_tx_rx u8n1_checker u_u8n1_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
